[rtl/mod_pkg.sv]
package mod_pkg;

	// Width of one acceleration sample.
	localparam int unsigned IN_W = 16;

	// Configuration register widths and values after reset.
	localparam int unsigned NOISE_W     = 15;
	localparam int unsigned RATIO_W     = 10;
	localparam logic [NOISE_W-1:0] NOISE_RESET = 15'd200;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 10'd101;

	// Samples per window, default for the top-level parameter.
	localparam int unsigned WINDOW_DEFAULT = 5;

	// APB port geometry: two registers on a 32-bit data bus, at byte addresses 0 and 4.
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// Register index, taken from paddr[2].
	typedef enum logic {
		REG_NOISE = 1'b0,
		REG_RATIO = 1'b1
	} reg_idx_t;

	// Stream widths.
	localparam int unsigned S_TDATA_W = 3 * IN_W;
	localparam int unsigned M_TDATA_W = 8;

endpackage

[rtl/motion_onset_detector.sv]
// Channel    | Direction | Signals                        | Content
// -----------+-----------+--------------------------------+-------------------------------
// s_axis     | in        | s_tvalid, s_tready, s_tdata    | one sample: accel_x, y, z
// m_axis     | out       | m_tvalid, m_tready, m_tdata    | one verdict: strum_detected
// apb        | in / out  | psel, penable, pwrite, paddr,  | noise_level at 0x0,
//            |           | pwdata, prdata, pready         | ratio_percent at 0x4
//
// One sample request is accepted in every cycle while the output side takes
// results. The last sample of a round moves from the input register to
// stage 2, which registers the closing sums, then to stage 3, which
// registers the magnitudes, noise test and products, and the compare lands
// in the output register. Reset clears the phase counter, the running sums,
// all stage valid bits and the configuration registers to their defaults.
// A stall on m_tready backs up only as far as needed: the pipeline keeps
// accepting samples until a stage holding a finished round cannot move.

module motion_onset_detector
	import mod_pkg::*;
#(
	parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Sample stream. s_tdata, low bit first: accel_x[15:0], accel_y[31:16],
	// accel_z[47:32], all signed two's complement.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	// Result stream. m_tdata, low bit first: strum_detected[0], zeros [7:1].
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	// Configuration port.
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	// A window sum of WINDOW samples needs clog2(WINDOW) bits above a sample.
	localparam int unsigned SUM_W = IN_W + $clog2(WINDOW);
	// Products and thresholds are compared at a width that holds all of them.
	localparam int unsigned CMP_W = SUM_W + 16;
	// Phase counter runs from 0 to 2*WINDOW-1.
	localparam int unsigned PH_W  = $clog2(2 * WINDOW);
	localparam logic [PH_W-1:0] PH_LAST   = PH_W'(2 * WINDOW - 1);
	localparam logic [PH_W-1:0] PH_WINDOW = PH_W'(WINDOW);

	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [CMP_W-1:0]        cmp_t;

	function automatic logic [SUM_W-1:0] magnitude(input sum_t v);
		magnitude = v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [NOISE_W-1:0] noise_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q <= NOISE_RESET;
			ratio_q <= RATIO_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_NOISE: noise_q <= pwdata[NOISE_W-1:0];
				REG_RATIO: ratio_q <= pwdata[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_NOISE: prdata = PDATA_W'(noise_q);
			REG_RATIO: prdata = PDATA_W'(ratio_q);
			default:   prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control. Each stage moves when the next one is empty or moving.
	// Only a round's closing sample needs room further down.
	// ------------------------------------------------------------------
	logic v1_s1, v2_s2, v3_s3, out_v_q;
	logic last_s1, is_ref_s1;
	logic rdy_out, rdy3, rdy2, rdy1;
	logic s_acc, move1, load2;

	assign rdy_out  = !out_v_q || m_tready;
	assign rdy3     = !v3_s3 || rdy_out;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || !last_s1 || rdy2;
	assign s_tready = rdy1;
	assign s_acc    = s_tvalid && s_tready;
	assign move1    = v1_s1 && rdy1;
	assign load2    = move1 && last_s1;

	// ------------------------------------------------------------------
	// Input register and phase counter.
	// ------------------------------------------------------------------
	logic [PH_W-1:0]       phase_q;
	logic signed [IN_W-1:0] samp_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			v1_s1     <= 1'b0;
			last_s1   <= 1'b0;
			is_ref_s1 <= 1'b0;
		end else begin
			if (s_acc) begin
				phase_q   <= (phase_q == PH_LAST) ? '0 : phase_q + PH_W'(1);
				v1_s1     <= 1'b1;
				last_s1   <= (phase_q == PH_LAST);
				is_ref_s1 <= (phase_q < PH_WINDOW);
			end else if (move1) begin
				v1_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			samp_s1[0] <= s_tdata[IN_W-1:0];
			samp_s1[1] <= s_tdata[2*IN_W-1:IN_W];
			samp_s1[2] <= s_tdata[3*IN_W-1:2*IN_W];
		end
	end

	// ------------------------------------------------------------------
	// Running sums. The closing sample always falls in the new window, so
	// its sum is completed on the way into stage 2 and the sums clear.
	// ------------------------------------------------------------------
	sum_t ref_sum_q [3];
	sum_t win_sum_q [3];
	sum_t ref_s2    [3];
	sum_t win_s2    [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				ref_sum_q[i] <= '0;
				win_sum_q[i] <= '0;
			end
		end else if (move1) begin
			for (int i = 0; i < 3; i++) begin
				if (last_s1) begin
					ref_sum_q[i] <= '0;
					win_sum_q[i] <= '0;
				end else if (is_ref_s1) begin
					ref_sum_q[i] <= ref_sum_q[i] + SUM_W'(samp_s1[i]);
				end else begin
					win_sum_q[i] <= win_sum_q[i] + SUM_W'(samp_s1[i]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (load2) begin
			v2_s2 <= 1'b1;
		end else if (rdy3) begin
			v2_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			for (int i = 0; i < 3; i++) begin
				ref_s2[i] <= ref_sum_q[i];
				win_s2[i] <= win_sum_q[i] + SUM_W'(samp_s1[i]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: magnitudes, noise test and the two growth products.
	// ------------------------------------------------------------------
	logic       move2;
	cmp_t       floor_lvl;
	cmp_t       mag_new [3];
	cmp_t       mag_ref [3];
	logic [2:0] loud_s3;
	cmp_t       prod_new_s3 [3];
	cmp_t       prod_ref_s3 [3];

	assign move2     = v2_s2 && rdy3;
	assign floor_lvl = CMP_W'(noise_q) * CMP_W'(WINDOW);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_new[i] = CMP_W'(magnitude(win_s2[i]));
			mag_ref[i] = CMP_W'(magnitude(ref_s2[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (move2) begin
			v3_s3 <= 1'b1;
		end else if (rdy_out) begin
			v3_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move2) begin
			for (int i = 0; i < 3; i++) begin
				loud_s3[i]     <= (mag_new[i] > floor_lvl);
				prod_new_s3[i] <= mag_new[i] * CMP_W'(100);
				prod_ref_s3[i] <= mag_ref[i] * CMP_W'(ratio_q);
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register: all axes loud and at least one grew.
	// ------------------------------------------------------------------
	logic move3, grew, det_q;

	assign move3 = v3_s3 && rdy_out;

	always_comb begin
		grew = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (prod_new_s3[i] > prod_ref_s3[i]) begin
				grew = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move3) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move3) begin
			det_q <= (&loud_s3) && grew;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(M_TDATA_W-1)'(0), det_q};

endmodule

[rtl/mod_checker.sv]
module mod_checker
	import mod_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic [PADDR_W-1:0]   paddr,
	input logic [PDATA_W-1:0]   pwdata,
	input logic [PDATA_W-1:0]   prdata,
	input logic                 pready
);

	// A stalled result stays offered with the same value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// With the output side taking results, the sample side never stalls.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("sample side stalled while output side was ready");

	// Padding bits of the result are always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:1] == '0)
		else $error("result padding not zero");

	// A noise level write reads back on the next cycle.
	a_noise_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[2] == 1'b0)
		##1 (paddr[2] == 1'b0)
		|-> prdata == PDATA_W'($past(pwdata[NOISE_W-1:0])))
		else $error("noise level read-back mismatch");

endmodule

bind motion_onset_detector mod_checker u_mod_checker (.*);
